// ===== src/pimu_pkg.sv =====
// ============================================================================
// pimu_pkg
// shared constants, types and codes of the priority inheriting mutex unit
// ============================================================================
package pimu_pkg;

    localparam int MAX_TASKS   = 16;
    localparam int NUM_MUTEXES = 8;
    localparam int MAX_DEPTH   = 255;

    localparam int TASK_W  = $clog2(MAX_TASKS);
    localparam int MUTEX_W = $clog2(NUM_MUTEXES);
    localparam int SCAN_W  = TASK_W + 1;
    localparam int DEPTH_W = 8;
    localparam int PRI_W   = 8;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 5;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [TASK_W-1:0]  task_idx_t;
    typedef logic [MUTEX_W-1:0] mutex_idx_t;
    typedef logic [PRI_W-1:0]   pri_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam cmd_t CMD_REGISTER = 2'd0;
    localparam cmd_t CMD_TAKE     = 2'd1;
    localparam cmd_t CMD_GIVE     = 2'd2;

    localparam status_t ST_ACQUIRED   = 3'd0;
    localparam status_t ST_NESTED     = 3'd1;
    localparam status_t ST_BLOCKED    = 3'd2;
    localparam status_t ST_HELD       = 3'd3;
    localparam status_t ST_RELEASED   = 3'd4;
    localparam status_t ST_NOT_OWNER  = 3'd5;
    localparam status_t ST_REGISTERED = 3'd6;
    localparam status_t ST_OVERFLOW   = 3'd7;

    localparam count_t TASK_COUNT_RESET = 5'd16;

endpackage

// ===== src/pimu_cmd_if.sv =====
// ============================================================================
// pimu_cmd_if
// request channel: command, task, mutex and base priority
// ============================================================================
interface pimu_cmd_if;
    import pimu_pkg::*;

    logic      valid;
    logic      ready;
    logic [1:0] command;
    logic [3:0] task_id;
    logic [2:0] mutex_id;
    logic [7:0] base_pri;

    modport source (output valid, output command, output task_id, output mutex_id,
                    output base_pri, input ready);
    modport sink   (input valid, input command, input task_id, input mutex_id,
                    input base_pri, output ready);
endinterface

// ===== src/pimu_res_if.sv =====
// ============================================================================
// pimu_res_if
// result channel: status, depth, woken task and owner report
// ============================================================================
interface pimu_res_if;
    import pimu_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] lock_depth;
    logic       woken_valid;
    logic [3:0] woken_task;
    logic [3:0] owner_task;
    logic [7:0] owner_priority;

    modport source (output valid, output status, output lock_depth, output woken_valid,
                    output woken_task, output owner_task, output owner_priority,
                    input ready);
    modport sink   (input valid, input status, input lock_depth, input woken_valid,
                    input woken_task, input owner_task, input owner_priority,
                    output ready);
endinterface

// ===== src/pimu_cfg_if.sv =====
// ============================================================================
// pimu_cfg_if
// configuration write channel for the task count register
// ============================================================================
interface pimu_cfg_if;
    import pimu_pkg::*;

    logic       valid;
    logic       ready;
    logic [4:0] task_count;

    modport source (output valid, output task_count, input ready);
    modport sink   (input valid, input task_count, output ready);
endinterface

// ===== src/priority_inheriting_mutex_unit.sv =====
// ============================================================================
// priority_inheriting_mutex_unit
// recursive mutexes with priority inheritance, run by a small sequencer
// ============================================================================
// sequence: capture the request, look up the mutex and the task priority, look up
//   the owner priority, then register the result; a releasing give first scans
//   min(task_count, 16) task entries; one request at a time, and the waiter scan
//   walks the task table one entry a cycle through one comparator
// reset: asynchronous active low; all mutexes free, task table zeroed, count 16
module priority_inheriting_mutex_unit (
    input  logic clk,
    input  logic rst_n,
    pimu_cmd_if.sink   cmd,
    pimu_res_if.source res,
    pimu_cfg_if.sink   cfg
);
    import pimu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_OWN  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_WAKE = 3'd5;

    logic [2:0] state_reg, state_next;

    logic       mutex_locked_reg [NUM_MUTEXES];
    task_idx_t  mutex_owner_reg  [NUM_MUTEXES];
    depth_t     mutex_depth_reg  [NUM_MUTEXES];
    pri_t       task_pri_reg     [MAX_TASKS];
    pri_t       task_base_reg    [MAX_TASKS];
    logic       task_wait_reg    [MAX_TASKS];
    mutex_idx_t task_wmutex_reg  [MAX_TASKS];

    count_t     count_reg;

    cmd_t       cmd_reg;
    task_idx_t  t_reg;
    mutex_idx_t m_reg;
    pri_t       bp_reg;
    logic       lk_reg;
    task_idx_t  own_reg;
    depth_t     dep_reg;
    pri_t       pri_t_reg;
    pri_t       pri_o_reg;

    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [SCAN_W-1:0] limit_reg, limit_next;
    logic       found_reg, found_next;
    pri_t       best_reg, best_next;
    task_idx_t  pick_reg, pick_next;

    logic       ovalid_reg;
    status_t    ostat_reg;
    depth_t     odep_reg;
    logic       owv_reg;
    task_idx_t  owt_reg;
    task_idx_t  oown_reg;
    pri_t       opri_reg;

    // write strobes from the sequencer
    logic       reg_we, take_new_we, take_nest_we, inherit_we, block_we;
    logic       hold_we, release_we, wake_we;
    logic       load_out;
    status_t    r_stat;
    depth_t     r_dep;
    logic       r_wv;
    task_idx_t  r_wt, r_own;
    pri_t       r_pri;

    // shared read port and comparator
    task_idx_t  tp_addr;
    pri_t       tp_rd;
    task_idx_t  scan_idx;
    pri_t       cmp_a, cmp_b;
    logic       cmp_gt;
    logic       out_free;
    logic       accept;
    logic       scan_hit;
    depth_t     dep_inc, dep_dec;

    assign accept   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free = !ovalid_reg || res.ready;
    assign scan_idx = scan_reg[TASK_W-1:0];
    assign dep_inc  = dep_reg + depth_t'(1);
    assign dep_dec  = (dep_reg != '0) ? dep_reg - depth_t'(1) : dep_reg;

    always_comb
    begin
        case (state_reg)
            S_LOOK:  tp_addr = t_reg;
            S_OWN:   tp_addr = own_reg;
            S_SCAN:  tp_addr = scan_idx;
            default: tp_addr = t_reg;
        endcase
    end

    assign tp_rd  = task_pri_reg[tp_addr];
    assign cmp_a  = (state_reg == S_SCAN) ? tp_rd : pri_t_reg;
    assign cmp_b  = (state_reg == S_SCAN) ? best_reg : pri_o_reg;
    assign cmp_gt = cmp_a > cmp_b;
    assign scan_hit = task_wait_reg[scan_idx] && (task_wmutex_reg[scan_idx] == m_reg)
                      && (!found_reg || cmp_gt);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        limit_next   = limit_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        reg_we       = 1'b0;
        take_new_we  = 1'b0;
        take_nest_we = 1'b0;
        inherit_we   = 1'b0;
        block_we     = 1'b0;
        hold_we      = 1'b0;
        release_we   = 1'b0;
        wake_we      = 1'b0;
        load_out     = 1'b0;
        r_stat       = ST_NOT_OWNER;
        r_dep        = dep_reg;
        r_wv         = 1'b0;
        r_wt         = '0;
        r_own        = lk_reg ? own_reg : '0;
        r_pri        = lk_reg ? pri_o_reg : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_OWN;
            end
            S_OWN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    load_out   = 1'b1;
                    case (cmd_reg)
                        CMD_REGISTER:
                        begin
                            reg_we = 1'b1;
                            r_stat = ST_REGISTERED;
                            r_dep  = '0;
                            r_own  = t_reg;
                            r_pri  = bp_reg;
                        end
                        CMD_TAKE:
                        begin
                            if (!lk_reg)
                            begin
                                take_new_we = 1'b1;
                                r_stat      = ST_ACQUIRED;
                                r_dep       = depth_t'(1);
                                r_own       = t_reg;
                                r_pri       = pri_t_reg;
                            end
                            else if (own_reg == t_reg)
                            begin
                                r_own = t_reg;
                                r_pri = pri_t_reg;
                                if (32'(dep_reg) >= MAX_DEPTH)
                                begin
                                    r_stat = ST_OVERFLOW;
                                end
                                else
                                begin
                                    take_nest_we = 1'b1;
                                    r_stat       = ST_NESTED;
                                    r_dep        = dep_inc;
                                end
                            end
                            else
                            begin
                                block_we   = 1'b1;
                                inherit_we = cmp_gt;
                                r_stat     = ST_BLOCKED;
                                r_pri      = cmp_gt ? pri_t_reg : pri_o_reg;
                            end
                        end
                        CMD_GIVE:
                        begin
                            if (lk_reg && own_reg == t_reg)
                            begin
                                if (dep_dec != '0)
                                begin
                                    hold_we = 1'b1;
                                    r_stat  = ST_HELD;
                                    r_dep   = dep_dec;
                                    r_pri   = pri_t_reg;
                                end
                                else
                                begin
                                    // last give: unlock and look for a waiter
                                    load_out   = 1'b0;
                                    release_we = 1'b1;
                                    scan_next  = '0;
                                    found_next = 1'b0;
                                    best_next  = '0;
                                    pick_next  = '0;
                                    if (32'(count_reg) > MAX_TASKS)
                                    begin
                                        limit_next = SCAN_W'(MAX_TASKS);
                                    end
                                    else
                                    begin
                                        limit_next = SCAN_W'(count_reg);
                                    end
                                    state_next = (limit_next == '0) ? S_WAKE : S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            r_stat = ST_NOT_OWNER;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    found_next = 1'b1;
                    best_next  = tp_rd;
                    pick_next  = scan_idx;
                end
                scan_next = scan_reg + SCAN_W'(1);
                if (scan_next == limit_reg)
                begin
                    state_next = S_WAKE;
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    load_out   = 1'b1;
                    wake_we    = found_reg;
                    r_stat     = ST_RELEASED;
                    r_dep      = '0;
                    r_wv       = found_reg;
                    r_wt       = pick_reg;
                    r_own      = '0;
                    r_pri      = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= TASK_COUNT_RESET;
            ovalid_reg <= 1'b0;
            scan_reg   <= '0;
            limit_reg  <= '0;
            found_reg  <= 1'b0;
            best_reg   <= '0;
            pick_reg   <= '0;
            for (int i = 0; i < NUM_MUTEXES; i++)
            begin
                mutex_locked_reg[i] <= 1'b0;
                mutex_owner_reg[i]  <= '0;
                mutex_depth_reg[i]  <= '0;
            end
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                task_pri_reg[i]    <= '0;
                task_base_reg[i]   <= '0;
                task_wait_reg[i]   <= 1'b0;
                task_wmutex_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            limit_reg <= limit_next;
            found_reg <= found_next;
            best_reg  <= best_next;
            pick_reg  <= pick_next;

            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.task_count;
            end

            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ovalid_reg <= 1'b0;
            end

            if (reg_we)
            begin
                task_base_reg[t_reg] <= bp_reg;
                task_pri_reg[t_reg]  <= bp_reg;
                task_wait_reg[t_reg] <= 1'b0;
            end
            if (take_new_we)
            begin
                mutex_locked_reg[m_reg] <= 1'b1;
                mutex_owner_reg[m_reg]  <= t_reg;
                mutex_depth_reg[m_reg]  <= depth_t'(1);
            end
            if (take_nest_we)
            begin
                mutex_depth_reg[m_reg] <= dep_inc;
            end
            if (inherit_we)
            begin
                task_pri_reg[own_reg] <= pri_t_reg;
            end
            if (block_we)
            begin
                task_wait_reg[t_reg]   <= 1'b1;
                task_wmutex_reg[t_reg] <= m_reg;
            end
            if (hold_we)
            begin
                mutex_depth_reg[m_reg] <= dep_dec;
            end
            if (release_we)
            begin
                mutex_locked_reg[m_reg] <= 1'b0;
                mutex_owner_reg[m_reg]  <= '0;
                mutex_depth_reg[m_reg]  <= dep_dec;
                task_pri_reg[t_reg]     <= task_base_reg[t_reg];
            end
            if (wake_we)
            begin
                task_wait_reg[pick_reg]   <= 1'b0;
                task_wmutex_reg[pick_reg] <= '0;
            end
        end
    end

    // request capture, operand lookup and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd.command;
            t_reg   <= task_idx_t'(cmd.task_id);
            m_reg   <= mutex_idx_t'(cmd.mutex_id);
            bp_reg  <= cmd.base_pri;
        end
        if (state_reg == S_LOOK)
        begin
            lk_reg    <= mutex_locked_reg[m_reg];
            own_reg   <= mutex_owner_reg[m_reg];
            dep_reg   <= mutex_depth_reg[m_reg];
            pri_t_reg <= tp_rd;
        end
        if (state_reg == S_OWN)
        begin
            pri_o_reg <= tp_rd;
        end
        if (load_out)
        begin
            ostat_reg <= r_stat;
            odep_reg  <= r_dep;
            owv_reg   <= r_wv;
            owt_reg   <= r_wt;
            oown_reg  <= r_own;
            opri_reg  <= r_pri;
        end
    end

    assign res.valid          = ovalid_reg;
    assign res.status         = ostat_reg;
    assign res.lock_depth     = odep_reg;
    assign res.woken_valid    = owv_reg;
    assign res.woken_task     = 4'(owt_reg);
    assign res.owner_task     = 4'(oown_reg);
    assign res.owner_priority = opri_reg;

endmodule

// ===== src/pimu_check.sv =====
// ============================================================================
// pimu_check
// port level checks of the mutex unit, bound to the top level
// ============================================================================
module pimu_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input pimu_pkg::status_t    status,
    input logic [7:0]           lock_depth,
    input logic                 woken_valid,
    input logic [3:0]           woken_task,
    input logic [3:0]           owner_task,
    input logic [7:0]           owner_priority
);
    import pimu_pkg::*;

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while a request is in flight");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(lock_depth)
            && $stable(woken_task) && $stable(owner_task))
        else $error("stalled result changed");

    a_wake_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && woken_valid |-> status == ST_RELEASED)
        else $error("waiter woken without a release");

    a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_RELEASED |->
            lock_depth == 8'd0 && owner_task == 4'd0 && owner_priority == 8'd0
            && (woken_valid || woken_task == 4'd0))
        else $error("release result reports a held mutex");

    a_register_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_REGISTERED |-> lock_depth == 8'd0 && !woken_valid)
        else $error("register result carries a lock depth");

endmodule

bind priority_inheriting_mutex_unit pimu_check u_pimu_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .status         (res.status),
    .lock_depth     (res.lock_depth),
    .woken_valid    (res.woken_valid),
    .woken_task     (res.woken_task),
    .owner_task     (res.owner_task),
    .owner_priority (res.owner_priority)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for priority_inheriting_mutex_unit. A ledger class
// tracks mutex ownership, lock depth, task priorities and waiters, predicts
// the report for every accepted request and compares it field by field with
// the reports the block returns. Directed requests cover registration,
// nesting, blocking with inheritance, ties on wake-up and the depth cap.
// Random phases follow, run under several task counts with random idling,
// one phase without idling and one long receiver hold-off.
// ============================================================================
module tb;
    import pimu_pkg::*;

    localparam cmd_t CMD_IGNORED  = 2'd3;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   STALL_LIMIT  = 4000;
    localparam int   DRAIN_CYCLES = 30;
    localparam int   PHASE_ITEMS  = 35;

    typedef struct packed {
        cmd_t       command;
        task_idx_t  task_id;
        mutex_idx_t mutex_id;
        pri_t       base_pri;
    } mutex_request_t;

    typedef struct packed {
        status_t   status;
        depth_t    lock_depth;
        logic      woken_valid;
        task_idx_t woken_task;
        task_idx_t owner_task;
        pri_t      owner_priority;
    } mutex_report_t;

    class mutex_ledger;
        bit            locked[NUM_MUTEXES];
        task_idx_t     owner[NUM_MUTEXES];
        int            depth[NUM_MUTEXES];
        pri_t          prio[MAX_TASKS];
        pri_t          base_prio[MAX_TASKS];
        bit            waiting[MAX_TASKS];
        mutex_idx_t    wait_on[MAX_TASKS];
        count_t        task_count;
        mutex_report_t pending_reports[$];
        int            errors;

        function new();
            foreach (locked[i])
            begin
                locked[i] = 1'b0;
                owner[i]  = '0;
                depth[i]  = 0;
            end
            foreach (prio[i])
            begin
                prio[i]      = '0;
                base_prio[i] = '0;
                waiting[i]   = 1'b0;
                wait_on[i]   = '0;
            end
            task_count = TASK_COUNT_RESET;
            errors     = 0;
        endfunction

        function mutex_report_t mutex_state(status_t st, mutex_idx_t m);
            mutex_report_t r;
            r.status      = st;
            r.lock_depth  = depth_t'(depth[m]);
            r.woken_valid = 1'b0;
            r.woken_task  = '0;
            if (locked[m])
            begin
                r.owner_task     = owner[m];
                r.owner_priority = prio[owner[m]];
            end
            else
            begin
                r.owner_task     = '0;
                r.owner_priority = '0;
            end
            return r;
        endfunction

        function mutex_report_t predict(mutex_request_t rq);
            mutex_report_t r;
            task_idx_t     t;
            mutex_idx_t    m;
            task_idx_t     o;
            task_idx_t     pick;
            pri_t          best;
            bit            found;
            int            limit;
            t = rq.task_id;
            m = rq.mutex_id;
            case (rq.command)
                CMD_REGISTER:
                begin
                    base_prio[t] = rq.base_pri;
                    prio[t]      = rq.base_pri;
                    waiting[t]   = 1'b0;
                    r = '{ST_REGISTERED, '0, 1'b0, '0, t, rq.base_pri};
                end
                CMD_TAKE:
                begin
                    if (!locked[m])
                    begin
                        locked[m] = 1'b1;
                        owner[m]  = t;
                        depth[m]  = 1;
                        r = mutex_state(ST_ACQUIRED, m);
                    end
                    else if (owner[m] == t)
                    begin
                        if (depth[m] >= MAX_DEPTH)
                            r = mutex_state(ST_OVERFLOW, m);
                        else
                        begin
                            depth[m]++;
                            r = mutex_state(ST_NESTED, m);
                        end
                    end
                    else
                    begin
                        o = owner[m];
                        if (prio[t] > prio[o])
                            prio[o] = prio[t];
                        waiting[t] = 1'b1;
                        wait_on[t] = m;
                        r = mutex_state(ST_BLOCKED, m);
                    end
                end
                CMD_GIVE:
                begin
                    if (locked[m] && owner[m] == t)
                    begin
                        if (depth[m] > 0)
                            depth[m]--;
                        if (depth[m] > 0)
                            r = mutex_state(ST_HELD, m);
                        else
                        begin
                            limit     = (task_count < MAX_TASKS) ? task_count : MAX_TASKS;
                            found     = 1'b0;
                            best      = '0;
                            pick      = '0;
                            locked[m] = 1'b0;
                            owner[m]  = '0;
                            prio[t]   = base_prio[t];
                            for (int i = 0; i < limit; i++)
                            begin
                                if (waiting[i] && wait_on[i] == m && (!found || prio[i] > best))
                                begin
                                    best  = prio[i];
                                    pick  = task_idx_t'(i);
                                    found = 1'b1;
                                end
                            end
                            if (found)
                            begin
                                waiting[pick] = 1'b0;
                                wait_on[pick] = '0;
                            end
                            r = '{ST_RELEASED, '0, found, pick, '0, '0};
                        end
                    end
                    else
                        r = mutex_state(ST_NOT_OWNER, m);
                end
                default:
                    r = mutex_state(ST_NOT_OWNER, m);
            endcase
            return r;
        endfunction

        function void note_request(mutex_request_t rq);
            pending_reports.push_back(predict(rq));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(mutex_report_t got);
            mutex_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("status: expected none, actual %0d", got.status);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare("status", want.status, got.status);
            compare("lock_depth", want.lock_depth, got.lock_depth);
            compare("woken_valid", want.woken_valid, got.woken_valid);
            compare("woken_task", want.woken_task, got.woken_task);
            compare("owner_task", want.owner_task, got.owner_task);
            compare("owner_priority", want.owner_priority, got.owner_priority);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pimu_cmd_if req_bus();
    pimu_res_if rep_bus();
    pimu_cfg_if cfg_bus();

    priority_inheriting_mutex_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (req_bus),
        .res   (rep_bus),
        .cfg   (cfg_bus)
    );

    mutex_ledger ledger = new();

    int sender_idle_pct = 33;
    int sink_stall_pct  = 33;
    bit hold_sink       = 1'b0;
    int quiet_cycles    = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // report monitor
    always @(posedge clk)
    begin
        if (rst_n && rep_bus.valid && rep_bus.ready)
            ledger.check_result('{rep_bus.status, rep_bus.lock_depth, rep_bus.woken_valid,
                                  rep_bus.woken_task, rep_bus.owner_task,
                                  rep_bus.owner_priority});
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rep_bus.valid && rep_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("priority_inheriting_mutex_unit: mismatch");
                $finish;
            end
        end
    end

    // report receiver
    initial
    begin
        rep_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                rep_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_sink = 1'b0;
            end
            rep_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_request(mutex_request_t rq);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid    = 1'b1;
        req_bus.command  = rq.command;
        req_bus.task_id  = rq.task_id;
        req_bus.mutex_id = rq.mutex_id;
        req_bus.base_pri = rq.base_pri;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        ledger.note_request(rq);
        @(negedge clk);
    endtask

    task automatic issue(cmd_t c, int t, int m, int p);
        push_request('{c, task_idx_t'(t), mutex_idx_t'(m), pri_t'(p)});
    endtask

    task automatic settle();
        req_bus.valid = 1'b0;
        while (ledger.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_task_count(count_t value);
        settle();
        cfg_bus.valid      = 1'b1;
        cfg_bus.task_count = value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        ledger.task_count = value;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic mutex_request_t random_request();
        mutex_request_t rq;
        int             roll;
        rq.task_id  = task_idx_t'($urandom_range(MAX_TASKS - 1));
        rq.mutex_id = ($urandom_range(99) < 60) ? mutex_idx_t'($urandom_range(2))
                                                : mutex_idx_t'($urandom_range(7));
        rq.base_pri = ($urandom_range(3) == 0) ? pri_t'(100) : pri_t'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 12)
            rq.command = CMD_REGISTER;
        else if (roll < 52)
            rq.command = CMD_TAKE;
        else if (roll < 94)
        begin
            rq.command = CMD_GIVE;
            repeat (4)
                if (!ledger.locked[rq.mutex_id])
                    rq.mutex_id = mutex_idx_t'($urandom_range(7));
            if (ledger.locked[rq.mutex_id] && $urandom_range(99) < 85)
                rq.task_id = ledger.owner[rq.mutex_id];
        end
        else
            rq.command = CMD_IGNORED;
        return rq;
    endfunction

    initial
    begin
        count_t phase_count;
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.command    = CMD_REGISTER;
        req_bus.task_id    = '0;
        req_bus.mutex_id   = '0;
        req_bus.base_pri   = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.task_count = TASK_COUNT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed requests
        issue(CMD_REGISTER, 0, 0, 0);
        issue(CMD_REGISTER, 15, 0, 255);
        issue(CMD_REGISTER, 5, 0, 100);
        issue(CMD_REGISTER, 6, 0, 100);
        issue(CMD_TAKE, 0, 7, 0);
        issue(CMD_TAKE, 0, 7, 0);
        issue(CMD_GIVE, 0, 7, 0);
        issue(CMD_TAKE, 5, 7, 0);
        issue(CMD_TAKE, 6, 7, 0);
        issue(CMD_GIVE, 3, 7, 0);
        issue(CMD_GIVE, 0, 7, 0);
        issue(CMD_GIVE, 2, 3, 0);
        issue(CMD_IGNORED, 15, 7, 255);
        issue(CMD_TAKE, 15, 0, 0);
        issue(CMD_TAKE, 0, 0, 0);
        issue(CMD_TAKE, 6, 0, 0);
        issue(CMD_REGISTER, 0, 0, 7);
        issue(CMD_GIVE, 15, 0, 0);
        issue(CMD_IGNORED, 0, 0, 0);

        // run one mutex up to the depth cap and back down
        issue(CMD_REGISTER, 9, 1, 42);
        for (int k = 0; k < MAX_DEPTH + 2; k++)
            issue(CMD_TAKE, 9, 1, 0);
        for (int k = 0; k < MAX_DEPTH; k++)
            issue(CMD_GIVE, 9, 1, 0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: phase_count = 5'd0;
                1: phase_count = 5'd1;
                2: phase_count = 5'd31;
                3: phase_count = 5'd16;
                4: phase_count = count_t'($urandom_range(1, MAX_TASKS));
                default: phase_count = count_t'($urandom_range(31));
            endcase
            write_task_count(phase_count);
            sender_idle_pct = (phase == 3) ? 0 : 33;
            sink_stall_pct  = (phase == 3) ? 0 : 33;
            if (phase == 1)
                hold_sink = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_request(random_request());
        end

        settle();
        if (ledger.errors == 0)
            $display("priority_inheriting_mutex_unit: match");
        else
            $display("priority_inheriting_mutex_unit: mismatch");
        $finish;
    end

endmodule
